// File: hw/rtl/hlr_pkg.sv
// Shared types and constants for the histogram largest-rectangle block.
package hlr_pkg;

	localparam int MAX_BARS_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;
	localparam int IN_H_W          = 16;
	localparam int AREA_W          = 26;
	localparam int POS_MAX_W       = 17;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	typedef struct packed {
		logic [IN_H_W-1:0] height;
		logic              last;
	} bar_t;

	typedef struct packed {
		logic [AREA_W-1:0] max_area;
		logic              overflow;
	} res_t;

	typedef enum logic {
		OP_BAR,
		OP_SKIP
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic                 last;
		logic [IN_H_W-1:0]    height;
		logic [POS_MAX_W-1:0] pos;
	} qent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_FILL,
		ST_FLUSH,
		ST_DONE
	} st_t;

endpackage

// File: hw/rtl/hlr_front.sv
// Front end: takes bar beats, assigns positions and marks bars beyond the stack depth.
module hlr_front #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          bar_valid,
	output logic          bar_stall,
	input  hlr_pkg::bar_t bar_data,
	input  logic          q_full,
	output logic          q_push,
	output hlr_pkg::qent_t q_ent
);
	import hlr_pkg::*;

	localparam int PW = $clog2(MAX_BARS + 1);
	localparam int HW = (HEIGHT_BITS < IN_H_W) ? HEIGHT_BITS : IN_H_W;

	logic [PW-1:0] pos_q;
	logic          full_bars;

	assign bar_stall = q_full;
	assign q_push    = bar_valid && !q_full;
	assign full_bars = (pos_q == PW'(MAX_BARS));

	always_comb begin
		q_ent.op     = full_bars ? OP_SKIP : OP_BAR;
		q_ent.last   = bar_data.last;
		q_ent.height = IN_H_W'(bar_data.height[HW-1:0]);
		q_ent.pos    = POS_MAX_W'(pos_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (bar_data.last) begin
				pos_q <= '0;
			end else if (!full_bars) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/hlr_queue.sv
// Small FIFO between the front end and the stack engine.
module hlr_queue #(
	parameter int DEPTH = hlr_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hlr_pkg::qent_t push_ent,
	output logic           full,
	output logic           vld,
	input  logic           pop,
	output hlr_pkg::qent_t pop_ent
);
	import hlr_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         ent_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign vld     = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && vld;
	assign pop_ent = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/hlr_back.sv
// Stack engine: monotonic stack in memory, area scoring pipeline and result register.
module hlr_back #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_vld,
	input  hlr_pkg::qent_t q_ent,
	output logic           q_pop,
	output logic           res_valid,
	input  logic           res_stall,
	output hlr_pkg::res_t  res_data
);
	import hlr_pkg::*;

	localparam int PW    = $clog2(MAX_BARS + 1);
	localparam int SW    = $clog2(MAX_BARS);
	localparam int HW    = (HEIGHT_BITS < IN_H_W) ? HEIGHT_BITS : IN_H_W;
	localparam int PRW   = HW + PW;
	localparam int EXT_W = (PRW > AREA_W) ? PRW : AREA_W;

	logic [HW-1:0] mem_h [MAX_BARS];
	logic [SW-1:0] mem_s [MAX_BARS];
	logic [HW-1:0] rd_h_q;
	logic [SW-1:0] rd_s_q;

	st_t           st_q;
	st_t           st_nxt;
	logic [PW-1:0] cnt_q;
	logic [HW-1:0] top_h_q;
	logic [SW-1:0] top_s_q;
	logic [HW-1:0] cur_h_q;
	logic [PW-1:0] cur_pos_q;
	logic [SW-1:0] start_q;
	logic          last_q;
	logic          fl_q;
	logic          ovf_q;
	logic [AREA_W-1:0] best_q;
	logic          res_vld_q;
	res_t          res_q;

	logic          sc_vld_s1;
	logic [HW-1:0] sc_h_s1;
	logic [PW-1:0] sc_w_s1;
	logic          sc_vld_s2;
	logic [PRW-1:0] sc_p_s2;
	logic [EXT_W-1:0] sc_ext;
	logic [AREA_W-1:0] sc_sat;

	logic          take;
	logic          pop_cond;
	logic          do_pop;
	logic          do_push;
	logic          emit;
	logic [PW-1:0] rd_idx;

	assign pop_cond = (cnt_q != '0) && (top_h_q > cur_h_q);
	assign rd_idx   = cnt_q - PW'(2);
	assign sc_ext   = EXT_W'(sc_p_s2);
	assign sc_sat   = (sc_ext > EXT_W'(AREA_MAX)) ? AREA_MAX : sc_ext[AREA_W-1:0];

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_vld) begin
					if (q_ent.op == OP_BAR) begin
						st_nxt = ST_POP;
					end else if (q_ent.last) begin
						st_nxt = ST_FLUSH;
					end
				end
			end
			ST_POP: begin
				if (pop_cond) begin
					st_nxt = ST_FILL;
				end else if (last_q) begin
					st_nxt = ST_FLUSH;
				end else begin
					st_nxt = ST_IDLE;
				end
			end
			ST_FILL: begin
				st_nxt = fl_q ? ST_FLUSH : ST_POP;
			end
			ST_FLUSH: begin
				st_nxt = (cnt_q != '0) ? ST_FILL : ST_DONE;
			end
			ST_DONE: begin
				if (emit) begin
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		take    = 1'b0;
		do_pop  = 1'b0;
		do_push = 1'b0;
		emit    = 1'b0;
		case (st_q)
			ST_IDLE: begin
				take = q_vld;
			end
			ST_POP: begin
				do_pop  = pop_cond;
				do_push = !pop_cond;
			end
			ST_FLUSH: begin
				do_pop = (cnt_q != '0);
			end
			ST_DONE: begin
				emit = !sc_vld_s1 && !sc_vld_s2 && (!res_vld_q || !res_stall);
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	assign q_pop     = take;
	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// stack memory, registered read of the entry below the popped top
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_h[cnt_q[SW-1:0]] <= cur_h_q;
			mem_s[cnt_q[SW-1:0]] <= start_q;
		end
		if (do_pop) begin
			rd_h_q <= mem_h[rd_idx[SW-1:0]];
			rd_s_q <= mem_s[rd_idx[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			fl_q      <= 1'b0;
			ovf_q     <= 1'b0;
			best_q    <= '0;
			res_vld_q <= 1'b0;
			sc_vld_s1 <= 1'b0;
			sc_vld_s2 <= 1'b0;
		end else begin
			st_q      <= st_nxt;
			sc_vld_s1 <= do_pop;
			sc_vld_s2 <= sc_vld_s1;
			if (take) begin
				last_q <= q_ent.last;
				ovf_q  <= ovf_q | (q_ent.op == OP_SKIP);
			end
			if (do_pop) begin
				cnt_q <= cnt_q - PW'(1);
			end else if (do_push) begin
				cnt_q <= cnt_q + PW'(1);
			end
			if (st_q == ST_FLUSH) begin
				fl_q <= 1'b1;
			end
			if (sc_vld_s2 && (sc_sat > best_q)) begin
				best_q <= sc_sat;
			end
			if (emit) begin
				res_vld_q <= 1'b1;
				best_q    <= '0;
				ovf_q     <= 1'b0;
				fl_q      <= 1'b0;
				cnt_q     <= '0;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sc_h_s1 <= top_h_q;
		sc_w_s1 <= cur_pos_q - PW'(top_s_q);
		sc_p_s2 <= PRW'(sc_h_s1) * PRW'(sc_w_s1);
		if (take) begin
			cur_h_q   <= q_ent.height[HW-1:0];
			cur_pos_q <= q_ent.pos[PW-1:0];
			start_q   <= q_ent.pos[SW-1:0];
		end
		if (do_pop) begin
			start_q <= top_s_q;
		end
		if (do_push) begin
			top_h_q   <= cur_h_q;
			top_s_q   <= start_q;
			cur_pos_q <= cur_pos_q + PW'(1);
		end
		if (st_q == ST_FILL) begin
			top_h_q <= rd_h_q;
			top_s_q <= rd_s_q;
		end
		if (emit) begin
			res_q.max_area <= best_q;
			res_q.overflow <= ovf_q;
		end
	end

endmodule

// File: hw/rtl/histogram_largest_rectangle.sv
// Top level: largest rectangle under a streamed histogram.
//
// Bar beats arrive on bar_valid/bar_stall/bar_data, one bar height per beat,
// with last marking the final bar of a histogram. One result beat per
// histogram leaves on res_valid/res_stall/res_data: the largest area,
// saturated to 26 bits, and a flag set when bars beyond MAX_BARS were dropped.
// The front end numbers bars and queues them (QUEUE_DEPTH entries); the stack
// engine behind it runs at its own pace. The engine takes a bar from the queue,
// pops every taller stack entry (each pop followed by a memory read of the new
// top) and then pushes the bar. Each bar within MAX_BARS is pushed and popped
// once. After the last bar the flush pops every remaining entry, then the
// scoring pipeline drains and the result is registered. A result waiting under
// res_stall does not block new bars; the engine only waits at the end of the
// next histogram until the result register is free. Reset clears all control
// state at once; the stack memory needs no clearing.
module histogram_largest_rectangle #(
	parameter int MAX_BARS    = hlr_pkg::MAX_BARS_DEF,
	parameter int HEIGHT_BITS = hlr_pkg::HEIGHT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          bar_valid,
	output logic          bar_stall,
	input  hlr_pkg::bar_t bar_data,
	output logic          res_valid,
	input  logic          res_stall,
	output hlr_pkg::res_t res_data
);
	import hlr_pkg::*;

	logic  f_push;
	qent_t f_ent;
	logic  q_full;
	logic  q_vld;
	logic  q_pop;
	qent_t q_ent;

	hlr_front #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_valid (bar_valid),
		.bar_stall (bar_stall),
		.bar_data  (bar_data),
		.q_full    (q_full),
		.q_push    (f_push),
		.q_ent     (f_ent)
	);

	hlr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.push_ent (f_ent),
		.full     (q_full),
		.vld      (q_vld),
		.pop      (q_pop),
		.pop_ent  (q_ent)
	);

	hlr_back #(
		.MAX_BARS    (MAX_BARS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_ent     (q_ent),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: hw/rtl/hlr_checker.sv
// Port-level checks for the histogram largest-rectangle block, bound to the top level.
module hlr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          bar_valid,
	input logic          bar_stall,
	input hlr_pkg::bar_t bar_data,
	input logic          res_valid,
	input logic          res_stall,
	input hlr_pkg::res_t res_data
);
	import hlr_pkg::*;

	logic [7:0] pend_q;
	logic       last_beat;
	logic       res_beat;

	assign last_beat = bar_valid && !bar_stall && bar_data.last;
	assign res_beat  = res_valid && !res_stall;

	// histograms closed but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (last_beat && !res_beat) begin
			pend_q <= pend_q + 8'd1;
		end else if (res_beat && !last_beat) begin
			pend_q <= pend_q - 8'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result beat changed under stall");

	a_res_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 8'd0)
		else $error("result beat without a closed histogram");

	a_no_res_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !res_valid)
		else $error("result beat straight after reset");

endmodule

bind histogram_largest_rectangle hlr_checker u_hlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.bar_valid (bar_valid),
	.bar_stall (bar_stall),
	.bar_data  (bar_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);
